[src/rxr_pkg.sv]
// Shared types and constants for the serial receive ring.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rxr_pkg;

   localparam int BYTE_W      = 8;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;

   localparam logic [OP_W-1:0] OP_ARRIVE = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TERMINAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESUME   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ABORT    = 2'd3;

   localparam logic [BYTE_W-1:0] TERMINAL_RST = 8'd10;
   localparam logic [BYTE_W-1:0] PAUSE_RST    = 8'd19;
   localparam logic [BYTE_W-1:0] RESUME_RST   = 8'd17;
   localparam logic [BYTE_W-1:0] ABORT_RST    = 8'd24;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_valid;
   } ctrl_status_type;

endpackage

[src/rxr_ctrl.sv]
// Controller for the serial receive ring: accepts one request, then runs it
// once the response register is free. Depends on rxr_pkg.
`timescale 1ns / 1ps

module rxr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     rsp_tready,
   input  rxr_pkg::ctrl_status_type status,
   output rxr_pkg::ctrl_cmd_type    cmd
);
   import rxr_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic run;

   assign req_tready  = (state_ff == ST_IDLE);
   assign run         = (state_ff == ST_EXEC) && (!status.rsp_valid || rsp_tready);
   assign cmd.capture = req_tvalid && req_tready;
   assign cmd.execute = run;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (run) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/rxr_datapath.sv]
// Datapath for the serial receive ring: byte store, pointers, flags,
// control-character registers and the response register. Depends on rxr_pkg.
`timescale 1ns / 1ps

module rxr_datapath #(
   parameter int RING_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rxr_pkg::ctrl_cmd_type               cmd,
   output rxr_pkg::ctrl_status_type            status,
   input  logic [rxr_pkg::OP_W-1:0]            req_tuser,
   input  logic [rxr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rxr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_wen,
   input  logic [rxr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rxr_pkg::BYTE_W-1:0]          csr_data
);
   import rxr_pkg::*;

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   logic [BYTE_W-1:0] mem [RING_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   logic [BYTE_W-1:0] term_ff, pause_ch_ff, resume_ch_ff, abort_ch_ff;

   logic [OP_W-1:0]   op_ff;
   logic [BYTE_W-1:0] byte_ff;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             pause_ff, pause_in;
   logic             abort_ff, abort_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rv, eom, drop, store;
   logic [BYTE_W-1:0] rb;
   logic [PTR_W-1:0] nx_wr;

   logic             o_rv_ff, o_eom_ff, o_ne_ff, o_pause_ff, o_abort_ff, o_drop_ff;
   logic [BYTE_W-1:0] o_rb_ff;

   assign nx_wr = ring_next(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      pause_in  = pause_ff;
      abort_in  = abort_ff;
      rv        = 1'b0;
      rb        = '0;
      eom       = 1'b0;
      drop      = 1'b0;
      store     = 1'b0;
      case (op_ff)
         OP_ARRIVE: begin
            if (nx_wr == rd_ptr_ff) begin
               drop = 1'b1;
            end else if (byte_ff == pause_ch_ff) begin
               pause_in = 1'b1;
            end else if (byte_ff == resume_ch_ff) begin
               pause_in = 1'b0;
            end else if (byte_ff == abort_ch_ff) begin
               abort_in = 1'b1;
            end else begin
               store     = 1'b1;
               wr_ptr_in = nx_wr;
            end
         end
         OP_POP: begin
            if (rd_ptr_ff != wr_ptr_ff) begin
               rv        = 1'b1;
               rb        = rd_data_ff;
               eom       = (rd_data_ff == term_ff) || (rd_data_ff == '0);
               rd_ptr_in = ring_next(rd_ptr_ff);
            end
         end
         OP_CLEAR: begin
            abort_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.execute && store) mem[wr_ptr_ff] <= byte_ff;
      rd_data_ff <= mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_tuser;
         byte_ff <= req_tdata;
      end
      if (cmd.execute) begin
         o_rv_ff    <= rv;
         o_rb_ff    <= rb;
         o_eom_ff   <= eom;
         o_ne_ff    <= (rd_ptr_in != wr_ptr_in);
         o_pause_ff <= pause_in;
         o_abort_ff <= abort_in;
         o_drop_ff  <= drop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         pause_ff     <= 1'b0;
         abort_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         term_ff      <= TERMINAL_RST;
         pause_ch_ff  <= PAUSE_RST;
         resume_ch_ff <= RESUME_RST;
         abort_ch_ff  <= ABORT_RST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.execute) begin
            wr_ptr_ff <= wr_ptr_in;
            rd_ptr_ff <= rd_ptr_in;
            pause_ff  <= pause_in;
            abort_ff  <= abort_in;
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_TERMINAL: term_ff      <= csr_data;
               CSR_PAUSE:    pause_ch_ff  <= csr_data;
               CSR_RESUME:   resume_ch_ff <= csr_data;
               CSR_ABORT:    abort_ch_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign status.rsp_valid = rsp_valid_ff;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tlast        = o_eom_ff;
   assign rsp_tdata        = {3'b000, o_drop_ff, o_abort_ff, o_pause_ff, o_ne_ff,
                              o_rb_ff, o_rv_ff};

endmodule

[src/serial_receive_ring_with_control_chars_top.sv]
// Top level of the serial receive ring with in-band control characters.
// Depends on rxr_pkg, rxr_ctrl and rxr_datapath.
//
// Usage:
//  - req_* carries one transaction per operation: op (arrive, pop, clear
//    abort) on req_tuser and the line byte on req_tdata. An arriving byte
//    is dropped if the ring is full; otherwise pause/resume/abort
//    characters update flags and other bytes are stored.
//  - rsp_* returns exactly one transaction per request: pop result, end of
//    message on rsp_tlast, and the ring and flag status after the operation.
//  - csr_* writes the terminal, pause, resume and abort characters by index;
//    write only while no request is outstanding. csr_ready is always high.
//  - Response: an accepted request executes once the response register is
//    free, and its result is registered there, raising rsp_tvalid.
//  - A new request is accepted only after the previous one has executed
//    (accept, then execute against the store's registered read port).
//  - A waiting response does not block acceptance of the next request; that
//    request executes once the response register is taken.
//  - The ring holds RING_DEPTH-1 bytes.
//  - Reset empties the ring, clears both flags and the response register,
//    and restores the default control characters. No clearing pass is needed.
`timescale 1ns / 1ps

module serial_receive_ring_with_control_chars_top #(
   parameter int RING_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] op
   input  logic [rxr_pkg::OP_W-1:0]            req_tuser,
   // [7:0] line_byte
   input  logic [rxr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] read_valid, [8:1] read_byte, [9] not_empty, [10] paused,
   // [11] abort_pending, [12] dropped, [15:13] zero
   output logic [rxr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rxr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rxr_pkg::BYTE_W-1:0]          csr_data
);
   import rxr_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   rxr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rxr_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_no_pop_and_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[12]))
      else $error("response reports both a popped byte and a drop");

   a_empty_pop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[8:1] == '0 && !rsp_tlast))
      else $error("read byte or end of message set without a popped byte");

   a_reset_clears_rsp: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

[tb/tb_serial_receive_ring_with_control_chars_top.sv]
// Self-checking testbench for the serial receive ring with control characters.
// Streams arrive/pop/clear operations, predicts each status transaction in
// place and checks it field by field. Depends on rxr_pkg and the top level.
`timescale 1ns / 1ps

module tb_serial_receive_ring_with_control_chars_top;

   import rxr_pkg::*;

   localparam int RING_DEPTH = 64;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] line_byte;
   } ring_op_type;

   typedef struct packed {
      logic              read_valid;
      logic [BYTE_W-1:0] read_byte;
      logic              end_of_message;
      logic              not_empty;
      logic              paused;
      logic              abort_pending;
      logic              dropped;
   } ring_status_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [BYTE_W-1:0]    value;
   } char_write_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [OP_W-1:0]        req_tuser = '0;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [BYTE_W-1:0]      csr_data = '0;

   // predicted ring state and control characters
   logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
   logic [PTR_W-1:0]  wr_ptr = '0;
   logic [PTR_W-1:0]  rd_ptr = '0;
   logic              pause_flag = 1'b0;
   logic              abort_flag = 1'b0;
   logic [BYTE_W-1:0] terminal_c = TERMINAL_RST;
   logic [BYTE_W-1:0] pause_c = PAUSE_RST;
   logic [BYTE_W-1:0] resume_c = RESUME_RST;
   logic [BYTE_W-1:0] abort_c = ABORT_RST;

   ring_op_type     line_ops [$];
   ring_status_type status_due [$];
   char_write_type  char_writes [$];
   int              errors = 0;
   bit              calm = 1'b0;

   serial_receive_ring_with_control_chars_top #(
      .RING_DEPTH(RING_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   task automatic ring_update(input ring_op_type item, output ring_status_type st);
      logic [PTR_W-1:0] nxt;
      st = '0;
      case (item.op)
         OP_ARRIVE: begin
            nxt = wr_ptr + 1'b1;
            if (nxt == rd_ptr) begin
               st.dropped = 1'b1;
            end else if (item.line_byte == pause_c) begin
               pause_flag = 1'b1;
            end else if (item.line_byte == resume_c) begin
               pause_flag = 1'b0;
            end else if (item.line_byte == abort_c) begin
               abort_flag = 1'b1;
            end else begin
               ring_mem[wr_ptr] = item.line_byte;
               wr_ptr = nxt;
            end
         end
         OP_POP: begin
            if (rd_ptr != wr_ptr) begin
               st.read_valid = 1'b1;
               st.read_byte = ring_mem[rd_ptr];
               st.end_of_message = (st.read_byte == terminal_c) || (st.read_byte == '0);
               rd_ptr = rd_ptr + 1'b1;
            end
         end
         OP_CLEAR: abort_flag = 1'b0;
         default: ;
      endcase
      st.not_empty = (rd_ptr != wr_ptr);
      st.paused = pause_flag;
      st.abort_pending = abort_flag;
   endtask

   task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                              input logic [BYTE_W-1:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin : drive_side
      ring_op_type     sent;
      ring_status_type st;
      char_write_type  wr;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TERMINAL: terminal_c = csr_data;
               CSR_PAUSE:    pause_c = csr_data;
               CSR_RESUME:   resume_c = csr_data;
               CSR_ABORT:    abort_c = csr_data;
               default: ;
            endcase
         end
         if (!csr_valid || csr_ready) begin
            if (char_writes.size() != 0) begin
               wr = char_writes.pop_front();
               csr_valid <= 1'b1;
               csr_index <= wr.index;
               csr_data <= wr.value;
            end else begin
               csr_valid <= 1'b0;
            end
         end
         if (req_tvalid && req_tready) begin
            sent.op = req_tuser;
            sent.line_byte = req_tdata;
            ring_update(sent, st);
            status_due.push_back(st);
         end
         if (!req_tvalid || req_tready) begin
            if (line_ops.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
               sent = line_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= sent.op;
               req_tdata <= sent.line_byte;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_side
      ring_status_type exp_st;
      rsp_tready <= calm || ($urandom_range(99) >= 35);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected response transaction, expected none, actual %0h last %0b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            exp_st = status_due.pop_front();
            check_field("read_valid", exp_st.read_valid, rsp_tdata[0]);
            check_field("read_byte", exp_st.read_byte, rsp_tdata[8:1]);
            check_field("end_of_message", exp_st.end_of_message, rsp_tlast);
            check_field("not_empty", exp_st.not_empty, rsp_tdata[9]);
            check_field("paused", exp_st.paused, rsp_tdata[10]);
            check_field("abort_pending", exp_st.abort_pending, rsp_tdata[11]);
            check_field("dropped", exp_st.dropped, rsp_tdata[12]);
         end
      end
   end

   task automatic wait_drained();
      do @(posedge clock);
      while (line_ops.size() != 0 || req_tvalid || status_due.size() != 0 ||
             char_writes.size() != 0 || csr_valid);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_chars(input logic [BYTE_W-1:0] t, input logic [BYTE_W-1:0] p,
                             input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] a);
      char_writes.push_back('{CSR_TERMINAL, t});
      char_writes.push_back('{CSR_PAUSE, p});
      char_writes.push_back('{CSR_RESUME, r});
      char_writes.push_back('{CSR_ABORT, a});
      wait_drained();
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte();
      int k;
      k = $urandom_range(99);
      if (k < 8) return pause_c;
      if (k < 14) return resume_c;
      if (k < 20) return abort_c;
      if (k < 26) return terminal_c;
      if (k < 30) return '0;
      return BYTE_W'($urandom_range(255));
   endfunction

   // alternating fill and drain bursts so the ring swings between empty and full
   task automatic push_bursts(input int count);
      int          k;
      int          len;
      bit          filling;
      ring_op_type item;
      filling = 1'b0;
      while (count > 0) begin
         filling = !filling;
         len = $urandom_range(10, 90);
         if (len > count) len = count;
         repeat (len) begin
            k = $urandom_range(99);
            item.line_byte = pick_byte();
            if (k < (filling ? 70 : 20)) item.op = OP_ARRIVE;
            else if (k < 90) item.op = OP_POP;
            else if (k < 97) item.op = OP_CLEAR;
            else item.op = OP_UNUSED;
            line_ops.push_back(item);
            count--;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, unused op, flags, stored extremes, terminal and zero
      line_ops.push_back('{OP_POP, 8'h00});
      line_ops.push_back('{OP_UNUSED, 8'hFF});
      line_ops.push_back('{OP_CLEAR, 8'h00});
      line_ops.push_back('{OP_ARRIVE, 8'h00});
      line_ops.push_back('{OP_ARRIVE, 8'hFF});
      line_ops.push_back('{OP_ARRIVE, TERMINAL_RST});
      line_ops.push_back('{OP_ARRIVE, 8'h5A});
      line_ops.push_back('{OP_ARRIVE, PAUSE_RST});
      line_ops.push_back('{OP_ARRIVE, ABORT_RST});
      line_ops.push_back('{OP_ARRIVE, RESUME_RST});
      line_ops.push_back('{OP_ARRIVE, PAUSE_RST});
      line_ops.push_back('{OP_UNUSED, 8'h00});
      repeat (5) line_ops.push_back('{OP_POP, 8'h00});
      line_ops.push_back('{OP_CLEAR, 8'hFF});
      line_ops.push_back('{OP_ARRIVE, 8'hA5});
      line_ops.push_back('{OP_ARRIVE, 8'h01});
      line_ops.push_back('{OP_POP, 8'h00});
      line_ops.push_back('{OP_POP, 8'h00});
      wait_drained();

      // fill to the brim, then control characters and data hit a full ring
      repeat (66) line_ops.push_back('{OP_ARRIVE, 8'h80 | 8'($urandom_range(127))});
      line_ops.push_back('{OP_ARRIVE, PAUSE_RST});
      line_ops.push_back('{OP_ARRIVE, RESUME_RST});
      line_ops.push_back('{OP_ARRIVE, ABORT_RST});
      line_ops.push_back('{OP_ARRIVE, 8'h33});
      push_bursts(100);
      wait_drained();

      calm = 1'b1;
      load_chars(8'h00, 8'h00, 8'h00, 8'h00);
      push_bursts(110);
      wait_drained();
      calm = 1'b0;

      load_chars(8'hFF, 8'hFF, 8'hFE, 8'hFE);
      push_bursts(110);
      wait_drained();

      load_chars(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      push_bursts(90);
      wait_drained();

      load_chars(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      push_bursts(90);
      wait_drained();

      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

[files.f]
src/rxr_pkg.sv
src/rxr_ctrl.sv
src/rxr_datapath.sv
src/serial_receive_ring_with_control_chars_top.sv
tb/tb_serial_receive_ring_with_control_chars_top.sv
